>>> rtl/lhf_pkg.sv
// ----------------------------------------------------------------------------
// lhf_pkg
// Shared constants, types and codes for the label hole filler.
// ----------------------------------------------------------------------------
package lhf_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int IROW_W = $clog2(MAX_ROWS + 2);
  localparam int CDIM_W = $clog2(MAX_COLS + 1);
  localparam int RDIM_W = $clog2(MAX_ROWS + 1);

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 2'd1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam int NBR     = 8;
  localparam int SCORE_W = 10;
  localparam logic [SCORE_W-1:0] SCORE_BASE = 10'd256;

  typedef struct packed {
    logic [7:0] label;
    logic [7:0] luma;
  } pix_t;

  typedef pix_t [8:0] win_t;

  typedef struct packed {
    logic valid;
    logic border;
    logic last;
  } ctl_t;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] label;
  } res_t;

  // Window position of each neighbour, top-left first.
  localparam int NB_IDX [NBR] = '{0, 1, 2, 3, 5, 6, 7, 8};

endpackage

>>> rtl/label_hole_fill_neighbour_vote.sv
// ----------------------------------------------------------------------------
// label_hole_fill_neighbour_vote
// Streaming label hole filler with a 3x3 neighbour vote.
// ----------------------------------------------------------------------------
// The block accepts one beat per clock unless the output stalls, and returns
// each pixel's final label one row plus one pixel after that pixel went in,
// in raster order, with tlast on the last pixel of the frame. After the last
// pixel of a frame, frame_cols + 1 drain beats (tuser high) flush the tail. A
// beat that does not fit the frame position is taken and dropped. A single
// line memory holds the two rows above the input row and is read and written
// back once per beat, so the rate is one beat per clock while the output does
// not stall. The memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module label_hole_fill_neighbour_vote
  import lhf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // luma, label_in
  input  logic                 in_tuser,   // command
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // label_out
  output logic                 out_tlast,  // frame_last
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CDIM_W-1:0] cols_r;
  logic [RDIM_W-1:0] rows_r;
  logic [COL_W-1:0]  in_col_r;
  logic [IROW_W-1:0] in_row_r;
  logic [COL_W-1:0]  ec_r;
  logic [ROW_W-1:0]  er_r;

  logic              s1_valid_r;
  ctl_t              s1_ctl_r, s2_ctl_r;
  logic [COL_W-1:0]  s1_addr_r;
  pix_t              s1_new_r;
  logic              fwd_hit_r;
  logic [31:0]       fwd_data_r;
  win_t              win_r;

  logic              out_valid_r, out_last_r;
  logic [7:0]        out_label_r;

  logic              adv, take, in_frame, emit, border, last, col_end;
  logic [31:0]       cfg_v, cfg_cols, cfg_rows;
  pix_t              newpix, top, mid;
  logic [31:0]       line, ram_rdata;
  res_t              res;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_v = 32'(cfg_data);
    if (cfg_v == 32'd0) begin
      cfg_cols = 32'd1;
      cfg_rows = 32'd1;
    end else begin
      cfg_cols = (cfg_v > 32'(MAX_COLS)) ? 32'(MAX_COLS) : cfg_v;
      cfg_rows = (cfg_v > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : cfg_v;
    end
  end

  always_comb begin
    in_frame = 32'(in_row_r) < 32'(rows_r);
    take = in_tvalid && adv &&
           ((in_tuser == CMD_DRAIN) ? !in_frame : in_frame);
    emit = (32'(in_row_r) >= 32'd2) ||
           ((32'(in_row_r) == 32'd1) && (in_col_r != '0));
    col_end = (32'(in_col_r) + 32'd1) == 32'(cols_r);
    border = (er_r == '0) || ((32'(er_r) + 32'd1) == 32'(rows_r)) ||
             (ec_r == '0) || ((32'(ec_r) + 32'd1) == 32'(cols_r));
    last = ((32'(er_r) + 32'd1) == 32'(rows_r)) &&
           ((32'(ec_r) + 32'd1) == 32'(cols_r));
    newpix = (in_tuser == CMD_DRAIN) ? '0 : pix_t'({in_tdata[7:0], in_tdata[15:8]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r   <= CDIM_W'(MAX_COLS);
      rows_r   <= RDIM_W'(MAX_ROWS);
      in_col_r <= '0;
      in_row_r <= '0;
      ec_r     <= '0;
      er_r     <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_FRAME_COLS) begin
        cols_r <= CDIM_W'(cfg_cols);
      end
      if (cfg_index == CFG_FRAME_COLS || cfg_index == CFG_FRAME_ROWS) begin
        in_col_r <= '0;
        in_row_r <= '0;
        ec_r     <= '0;
        er_r     <= '0;
      end
      if (cfg_index == CFG_FRAME_ROWS) begin
        rows_r <= RDIM_W'(cfg_rows);
      end
    end else if (take) begin
      if (emit && last) begin
        in_col_r <= '0;
        in_row_r <= '0;
        ec_r     <= '0;
        er_r     <= '0;
      end else begin
        if (col_end) begin
          in_col_r <= '0;
          in_row_r <= in_row_r + 1'b1;
        end else begin
          in_col_r <= in_col_r + 1'b1;
        end
        if (emit) begin
          if ((32'(ec_r) + 32'd1) == 32'(cols_r)) begin
            ec_r <= '0;
            er_r <= er_r + 1'b1;
          end else begin
            ec_r <= ec_r + 1'b1;
          end
        end
      end
    end
  end

  lhf_line_ram #(
    .ADDR_W (COL_W),
    .DATA_W (32)
  ) u_line_ram (
    .clk   (clk),
    .we    (adv && s1_valid_r),
    .waddr (s1_addr_r),
    .wdata ({mid, s1_new_r}),
    .re    (adv),
    .raddr (in_col_r),
    .rdata (ram_rdata)
  );

  assign line = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign top  = pix_t'(line[31:16]);
  assign mid  = pix_t'(line[15:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_ctl_r   <= '0;
      s2_ctl_r   <= '0;
      fwd_hit_r  <= 1'b0;
      win_r      <= '0;
    end else if (adv) begin
      s1_valid_r      <= take;
      s1_ctl_r.valid  <= take && emit;
      s1_ctl_r.border <= border;
      s1_ctl_r.last   <= last;
      s2_ctl_r        <= s1_valid_r ? s1_ctl_r : '0;
      fwd_hit_r       <= s1_valid_r && (s1_addr_r == in_col_r);
      if (s1_valid_r) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r*3]     <= win_r[r*3 + 1];
          win_r[r*3 + 1] <= win_r[r*3 + 2];
        end
        win_r[2] <= top;
        win_r[5] <= mid;
        win_r[8] <= s1_new_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_addr_r  <= in_col_r;
      s1_new_r   <= newpix;
      fwd_data_r <= {mid, s1_new_r};
    end
  end

  lhf_vote u_vote (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .ctl_in (s2_ctl_r),
    .win    (win_r),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_label_r <= res.label;
      out_last_r  <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_label_r;
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/lhf_line_ram.sv
// ----------------------------------------------------------------------------
// lhf_line_ram
// Simple dual-port line memory with one write port and a registered read.
// ----------------------------------------------------------------------------
module lhf_line_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/lhf_vote.sv
// ----------------------------------------------------------------------------
// lhf_vote
// Neighbour vote: label matching, group scoring, best pick.
// ----------------------------------------------------------------------------
module lhf_vote
  import lhf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  ctl_t ctl_in,
  input  win_t win,
  output res_t res
);

  ctl_t                  s3_ctl_r, s4_ctl_r;
  logic [7:0]            s3_centre_r, s4_centre_r;
  logic [NBR-1:0][7:0]   s3_lab_r, s4_lab_r;
  logic [NBR-1:0][7:0]   s3_diff_r;
  logic [NBR-1:0][NBR-1:0] s3_eq_r;
  logic [NBR-1:0][SCORE_W-1:0] s4_score_r;

  logic [NBR-1:0][7:0]   lab_nxt, diff_nxt;
  logic [NBR-1:0][NBR-1:0] eq_nxt;
  logic [NBR-1:0][SCORE_W-1:0] score_nxt;

  always_comb begin
    logic [7:0] y0, y;
    y0 = win[4].luma;
    for (int k = 0; k < NBR; k++) begin
      y = win[NB_IDX[k]].luma;
      lab_nxt[k] = win[NB_IDX[k]].label;
      diff_nxt[k] = (y > y0) ? (y - y0) : (y0 - y);
    end
    for (int k = 0; k < NBR; k++) begin
      for (int j = 0; j < NBR; j++) begin
        eq_nxt[k][j] = (lab_nxt[k] == lab_nxt[j]);
      end
    end
  end

  always_comb begin
    logic [7:0] dmin;
    logic [3:0] cnt;
    for (int k = 0; k < NBR; k++) begin
      dmin = 8'hFF;
      for (int j = 0; j < NBR; j++) begin
        if (s3_eq_r[k][j] && (s3_diff_r[j] < dmin)) begin
          dmin = s3_diff_r[j];
        end
      end
      cnt = 4'($countones(s3_eq_r[k]));
      score_nxt[k] = {1'b0, cnt, 5'b0} + SCORE_BASE - {2'b0, dmin};
    end
  end

  always_comb begin
    logic [SCORE_W-1:0] best_score;
    logic [7:0]         best_lab;
    best_score = s4_score_r[0];
    best_lab   = s4_lab_r[0];
    for (int k = 1; k < NBR; k++) begin
      if (s4_score_r[k] > best_score) begin
        best_score = s4_score_r[k];
        best_lab   = s4_lab_r[k];
      end
    end
    res.valid = s4_ctl_r.valid;
    res.last  = s4_ctl_r.last;
    if (s4_ctl_r.border || (s4_centre_r != 8'd0)) begin
      res.label = s4_centre_r;
    end else begin
      res.label = best_lab;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r <= '0;
      s4_ctl_r <= '0;
    end else if (adv) begin
      s3_ctl_r <= ctl_in;
      s4_ctl_r <= s3_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_centre_r <= win[4].label;
      s3_lab_r    <= lab_nxt;
      s3_diff_r   <= diff_nxt;
      s3_eq_r     <= eq_nxt;
      s4_centre_r <= s3_centre_r;
      s4_lab_r    <= s3_lab_r;
      s4_score_r  <= score_nxt;
    end
  end

endmodule
